[design/ipd_mqtt_publish_extractor_defines.svh]
// Assertion macros shared by the MQTT publish extractor RTL.
// Included by files that carry concurrent assertions; depends on nothing.
`ifndef IPD_MQTT_PUBLISH_EXTRACTOR_DEFINES_SVH
`define IPD_MQTT_PUBLISH_EXTRACTOR_DEFINES_SVH
`ifndef SYNTHESIS
`define IPD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define IPD_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define IPD_ASSERT(label, prop, msg)
`define IPD_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

[design/ipd_pkg.sv]
// Types, codes and constants of the MQTT publish extractor.
// Used by the parser, the result queue and the top level; depends on nothing.
package ipd_pkg;

    typedef enum logic [3:0] {
        PH_HUNT    = 4'd0,
        PH_LEN     = 4'd1,
        PH_FIXED   = 4'd2,
        PH_REMLEN  = 4'd3,
        PH_TLEN_HI = 4'd4,
        PH_TLEN_LO = 4'd5,
        PH_TOPIC   = 4'd6,
        PH_ID      = 4'd7,
        PH_PAYLOAD = 4'd8,
        PH_TAIL    = 4'd9,
        PH_SKIP    = 4'd10
    } phase_t;

    typedef enum logic [1:0] {
        KIND_TOPIC   = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_DONE    = 2'd2,
        KIND_DROP    = 2'd3
    } kind_t;

    localparam logic CFG_TOPIC_LIMIT   = 1'b0;
    localparam logic CFG_PAYLOAD_LIMIT = 1'b1;

    localparam logic [9:0] TOPIC_LIMIT_RESET   = 10'd63;
    localparam logic [9:0] PAYLOAD_LIMIT_RESET = 10'd127;

    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_0     = 8'h30;
    localparam logic [7:0] CHAR_9     = 8'h39;

    localparam int RFIFO_DEPTH = 4;
    localparam int RFIFO_AW    = 2;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
        logic       last;
    } result_t;

    typedef struct packed {
        logic [9:0] topic_limit;
        logic [9:0] payload_limit;
    } cfg_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } step_res_t;

    function automatic logic [7:0] hdr_char(input logic [2:0] pos);
        logic [7:0] c;
        unique case (pos)
            3'd0:    c = 8'h2B;
            3'd1:    c = 8'h49;
            3'd2:    c = 8'h50;
            3'd3:    c = 8'h44;
            3'd4:    c = 8'h2C;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

[design/ipd_mqtt_publish_extractor.sv]
// Top level of the MQTT publish extractor: input register, parser and result queue.
// Depends on ipd_pkg, ipd_parse, ipd_rfifo and the assertion macro header.
//
// Modem receive bytes arrive on the input channel (in_valid, in_stall, rx_byte), one
// byte per beat. Each beat yields zero, one or two result beats on the output channel
// (out_valid, out_stall, kind, data, last): topic bytes, payload bytes, a done marker
// closing a message, or a dropped marker for a frame that is refused. The last flag is
// set on the final result caused by one input byte.
// The limits are written through cfg_we, cfg_index and cfg_data while the block is idle.
// A byte is registered in the input register at its accepting edge and is parsed into
// a four-entry result queue at the next edge on which the queue holds at most two
// entries; the queue offers a result in the cycle after such a push.
// One byte is accepted per cycle as long as the queue has room for two results; the
// output drains one result per cycle while the receiver does not stall, so bytes that
// yield two results use twice the output bandwidth of bytes that yield one. When the
// receiver stalls, results wait in the queue and in_stall rises while a byte waits in
// the input register and the queue holds more than two entries.
// Reset returns the parser to hunting for the header text and restores the limits
// to 63 topic bytes and 127 payload bytes.
`include "ipd_mqtt_publish_extractor_defines.svh"
module ipd_mqtt_publish_extractor
    import ipd_pkg::*;
#(
    parameter int unsigned MAX_FRAME = 1024
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] kind,
    output logic [7:0] data,
    output logic       last,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [9:0] cfg_data
);

    logic                in_valid_reg, in_valid_next;
    logic [7:0]          in_byte_reg;
    cfg_t                cfg_reg, cfg_next;
    logic                go;
    logic                accept;
    logic                pop;
    step_res_t           step;
    result_t             head;
    logic [RFIFO_AW:0]   fifo_level;

    assign go        = in_valid_reg && (fifo_level <= 3'd2);
    assign in_stall  = in_valid_reg && (fifo_level > 3'd2);
    assign accept    = in_valid && !in_stall;
    assign out_valid = (fifo_level != 3'd0);
    assign pop       = out_valid && !out_stall;
    assign kind      = head.kind;
    assign data      = head.data;
    assign last      = head.last;

    always_comb
    begin
        if (accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (go)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end
    end

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_TOPIC_LIMIT:   cfg_next.topic_limit   = cfg_data;
                CFG_PAYLOAD_LIMIT: cfg_next.payload_limit = cfg_data;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg          <= 1'b0;
            cfg_reg.topic_limit   <= TOPIC_LIMIT_RESET;
            cfg_reg.payload_limit <= PAYLOAD_LIMIT_RESET;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            cfg_reg      <= cfg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_byte_reg <= rx_byte;
        end
    end

    ipd_parse #(
        .MAX_FRAME (MAX_FRAME)
    ) u_parse (
        .clk     (clk),
        .rst_n   (rst_n),
        .go      (go),
        .rx_byte (in_byte_reg),
        .cfg     (cfg_reg),
        .step    (step)
    );

    ipd_rfifo u_rfifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .push_n (go ? step.count : 2'd0),
        .push_a (step.first),
        .push_b (step.second),
        .pop    (pop),
        .head   (head),
        .level  (fifo_level)
    );

    `IPD_ASSERT(a_level_bound, fifo_level <= 3'd4, "result queue level out of range")
    `IPD_ASSERT(a_pair_ends_done, (go && step.count == 2'd2) |-> (step.second.kind == KIND_DONE && step.second.last && !step.first.last), "two results must end with a done marker")
    `IPD_ASSERT(a_single_last, (go && step.count == 2'd1) |-> step.first.last, "single result lacks last flag")
    `IPD_ASSERT(a_push_shows, (go && step.count != 2'd0) |=> out_valid, "pushed result not offered")

endmodule

[design/ipd_parse.sv]
// Parser state and per-beat step logic of the MQTT publish extractor.
// Depends on ipd_pkg; produces up to two results for each processed byte.
module ipd_parse
    import ipd_pkg::*;
#(
    parameter int unsigned MAX_FRAME = 1024
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      go,
    input  logic [7:0] rx_byte,
    input  cfg_t      cfg,
    output step_res_t step
);

    phase_t      phase_reg, phase_next;
    logic [2:0]  match_reg, match_next;
    logic [15:0] frame_left_reg, frame_left_next;
    logic [27:0] rem_len_reg, rem_len_next;
    logic [1:0]  group_reg, group_next;
    logic [1:0]  qos_reg, qos_next;
    logic [15:0] topic_size_reg, topic_size_next;
    logic [27:0] field_cnt_reg, field_cnt_next;
    logic [9:0]  emitted_reg, emitted_next;
    logic        len_seen_reg, len_seen_next;

    logic        data_put;
    kind_t       data_kind;
    logic        mark_a;
    logic        mark_b;
    kind_t       mark_b_kind;
    logic        topic_end;
    logic        pay_start;
    logic [19:0] len_mul;
    logic [16:0] over;
    logic [1:0]  res_cnt;

    always_comb
    begin
        phase_next      = phase_reg;
        match_next      = match_reg;
        frame_left_next = frame_left_reg;
        rem_len_next    = rem_len_reg;
        group_next      = group_reg;
        qos_next        = qos_reg;
        topic_size_next = topic_size_reg;
        field_cnt_next  = field_cnt_reg;
        emitted_next    = emitted_reg;
        len_seen_next   = len_seen_reg;
        data_put        = 1'b0;
        data_kind       = KIND_TOPIC;
        mark_a          = 1'b0;
        mark_b          = 1'b0;
        mark_b_kind     = KIND_DONE;
        topic_end       = 1'b0;
        pay_start       = 1'b0;
        len_mul         = '0;
        over            = '0;

        unique case (phase_reg)
            PH_HUNT:
            begin
                if (rx_byte == hdr_char(match_reg))
                begin
                    if (match_reg == 3'd4)
                    begin
                        match_next      = 3'd0;
                        phase_next      = PH_LEN;
                        frame_left_next = 16'd0;
                        len_seen_next   = 1'b0;
                    end
                    else
                    begin
                        match_next = match_reg + 3'd1;
                    end
                end
                else
                begin
                    match_next = (rx_byte == CHAR_PLUS) ? 3'd1 : 3'd0;
                end
            end
            PH_LEN:
            begin
                if (rx_byte >= CHAR_0 && rx_byte <= CHAR_9)
                begin
                    len_mul = ({4'd0, frame_left_reg} << 3) + ({4'd0, frame_left_reg} << 1)
                              + {16'd0, rx_byte[3:0]};
                    frame_left_next = (len_mul > 20'h0FFFF) ? 16'hFFFF : len_mul[15:0];
                    len_seen_next   = 1'b1;
                end
                else if (rx_byte == CHAR_COLON && len_seen_reg)
                begin
                    if (frame_left_reg == 16'd0)
                    begin
                        mark_b      = 1'b1;
                        mark_b_kind = KIND_DROP;
                        phase_next  = PH_HUNT;
                        match_next  = 3'd0;
                    end
                    else if (frame_left_reg > 16'(MAX_FRAME))
                    begin
                        phase_next = PH_SKIP;
                    end
                    else
                    begin
                        phase_next = PH_FIXED;
                    end
                end
                else
                begin
                    phase_next      = PH_HUNT;
                    frame_left_next = 16'd0;
                    match_next      = (rx_byte == CHAR_PLUS) ? 3'd1 : 3'd0;
                end
            end
            PH_FIXED, PH_REMLEN, PH_TLEN_HI, PH_TLEN_LO, PH_TOPIC, PH_ID, PH_PAYLOAD,
            PH_TAIL, PH_SKIP:
            begin
                frame_left_next = frame_left_reg - 16'd1;
                unique case (phase_reg)
                    PH_FIXED:
                    begin
                        if (rx_byte[7:4] == 4'h3)
                        begin
                            qos_next     = rx_byte[2:1];
                            rem_len_next = 28'd0;
                            group_next   = 2'd0;
                            phase_next   = PH_REMLEN;
                        end
                        else
                        begin
                            phase_next = PH_SKIP;
                        end
                    end
                    PH_REMLEN:
                    begin
                        rem_len_next = rem_len_reg
                                       | ({21'd0, rx_byte[6:0]} << (5'd7 * {3'd0, group_reg}));
                        if (rx_byte[7] && group_reg < 2'd3)
                        begin
                            group_next = group_reg + 2'd1;
                        end
                        else
                        begin
                            phase_next = PH_TLEN_HI;
                        end
                    end
                    PH_TLEN_HI:
                    begin
                        topic_size_next = {rx_byte, 8'h00};
                        phase_next      = PH_TLEN_LO;
                    end
                    PH_TLEN_LO:
                    begin
                        topic_size_next = topic_size_reg | {8'h00, rx_byte};
                        over = 17'd2 + {1'b0, topic_size_next}
                               + ((qos_reg != 2'd0) ? 17'd2 : 17'd0);
                        rem_len_next = (rem_len_reg > {11'd0, over})
                                       ? rem_len_reg - {11'd0, over} : 28'd0;
                        field_cnt_next = {12'd0, topic_size_next};
                        emitted_next   = 10'd0;
                        phase_next     = PH_TOPIC;
                        topic_end      = (topic_size_next == 16'd0);
                    end
                    PH_TOPIC:
                    begin
                        if (emitted_reg < cfg.topic_limit)
                        begin
                            data_put     = 1'b1;
                            data_kind    = KIND_TOPIC;
                            emitted_next = emitted_reg + 10'd1;
                        end
                        field_cnt_next = field_cnt_reg - 28'd1;
                        topic_end      = (field_cnt_reg == 28'd1);
                    end
                    PH_ID:
                    begin
                        field_cnt_next = field_cnt_reg - 28'd1;
                        pay_start      = (field_cnt_reg == 28'd1);
                    end
                    PH_PAYLOAD:
                    begin
                        if (emitted_reg < cfg.payload_limit)
                        begin
                            data_put     = 1'b1;
                            data_kind    = KIND_PAYLOAD;
                            emitted_next = emitted_reg + 10'd1;
                        end
                        field_cnt_next = field_cnt_reg - 28'd1;
                        if (field_cnt_reg == 28'd1)
                        begin
                            mark_a     = 1'b1;
                            phase_next = PH_TAIL;
                        end
                    end
                    default:
                    begin
                    end
                endcase

                if (topic_end)
                begin
                    if (qos_reg != 2'd0)
                    begin
                        field_cnt_next = 28'd2;
                        phase_next     = PH_ID;
                    end
                    else
                    begin
                        pay_start = 1'b1;
                    end
                end

                if (pay_start)
                begin
                    field_cnt_next = rem_len_next;
                    emitted_next   = 10'd0;
                    phase_next     = PH_PAYLOAD;
                    if (rem_len_next == 28'd0)
                    begin
                        mark_a     = 1'b1;
                        phase_next = PH_TAIL;
                    end
                end

                if (frame_left_next == 16'd0)
                begin
                    if (phase_next >= PH_REMLEN && phase_next <= PH_PAYLOAD)
                    begin
                        mark_b      = 1'b1;
                        mark_b_kind = KIND_DONE;
                    end
                    else if (phase_next == PH_SKIP)
                    begin
                        mark_b      = 1'b1;
                        mark_b_kind = KIND_DROP;
                    end
                    phase_next = PH_HUNT;
                    match_next = 3'd0;
                end
            end
            default:
            begin
                phase_next = PH_HUNT;
                match_next = (rx_byte == CHAR_PLUS) ? 3'd1 : 3'd0;
            end
        endcase
    end

    always_comb
    begin
        res_cnt = {1'b0, data_put} + {1'b0, mark_a} + {1'b0, mark_b};
        if (res_cnt > 2'd2)
        begin
            res_cnt = 2'd2;
        end
        step.count = res_cnt;

        if (data_put)
        begin
            step.first.kind = data_kind;
            step.first.data = rx_byte;
        end
        else if (mark_a)
        begin
            step.first.kind = KIND_DONE;
            step.first.data = 8'h00;
        end
        else
        begin
            step.first.kind = mark_b_kind;
            step.first.data = 8'h00;
        end

        step.second.data = 8'h00;
        if (data_put && mark_a)
        begin
            step.second.kind = KIND_DONE;
        end
        else
        begin
            step.second.kind = mark_b_kind;
        end

        step.first.last  = (res_cnt == 2'd1);
        step.second.last = (res_cnt == 2'd2);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HUNT;
            match_reg      <= 3'd0;
            frame_left_reg <= 16'd0;
            rem_len_reg    <= 28'd0;
            group_reg      <= 2'd0;
            qos_reg        <= 2'd0;
            topic_size_reg <= 16'd0;
            field_cnt_reg  <= 28'd0;
            emitted_reg    <= 10'd0;
            len_seen_reg   <= 1'b0;
        end
        else if (go)
        begin
            phase_reg      <= phase_next;
            match_reg      <= match_next;
            frame_left_reg <= frame_left_next;
            rem_len_reg    <= rem_len_next;
            group_reg      <= group_next;
            qos_reg        <= qos_next;
            topic_size_reg <= topic_size_next;
            field_cnt_reg  <= field_cnt_next;
            emitted_reg    <= emitted_next;
            len_seen_reg   <= len_seen_next;
        end
    end

endmodule

[design/ipd_rfifo.sv]
// Four-entry result queue of the MQTT publish extractor.
// Depends on ipd_pkg; takes up to two results per cycle and releases one.
module ipd_rfifo
    import ipd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [1:0]            push_n,
    input  result_t               push_a,
    input  result_t               push_b,
    input  logic                  pop,
    output result_t               head,
    output logic [RFIFO_AW:0]     level
);

    result_t                 entries_reg [RFIFO_DEPTH];
    logic [RFIFO_AW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [RFIFO_AW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [RFIFO_AW:0]       level_reg, level_next;
    logic [RFIFO_AW-1:0]     wr_ptr_b;

    assign wr_ptr_b = wr_ptr_reg + RFIFO_AW'(1);
    assign head     = entries_reg[rd_ptr_reg];
    assign level    = level_reg;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + push_n[RFIFO_AW-1:0];
        rd_ptr_next = rd_ptr_reg + RFIFO_AW'(pop);
        level_next  = level_reg + {1'b0, push_n} - {{RFIFO_AW{1'b0}}, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
        begin
            entries_reg[wr_ptr_reg] <= push_a;
        end
        if (push_n == 2'd2)
        begin
            entries_reg[wr_ptr_b] <= push_b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

endmodule

[tb/ipd_publish_checker.sv]
// Checker for the MQTT publish extractor: predicts the result beats of every accepted
// input byte and compares them, in order, with the beats the block delivers.
// Depends on ipd_pkg for the result and phase types and the character constants.
module ipd_publish_checker
    import ipd_pkg::*;
#(
    parameter int unsigned MAX_FRAME = 1024
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_stall,
    input  logic [7:0] rx_byte,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic [1:0] kind,
    input  logic [7:0] data,
    input  logic       last,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [9:0] cfg_data,
    output int         outstanding,
    output int         errors
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [39:0] HEADER_TEXT = "+IPD,";

    phase_t      stage;
    logic [2:0]  hdr_matched;
    logic [15:0] frame_bytes_left;
    logic [27:0] rem_len;
    logic [1:0]  len_group;
    logic [1:0]  qos;
    logic [15:0] topic_size;
    logic [27:0] field_left;
    logic [9:0]  passed_count;
    logic        len_digit_seen;
    logic [9:0]  topic_max;
    logic [9:0]  payload_max;
    result_t     step_res [2];
    int          step_cnt;
    result_t     expected_results [$];
    result_t     exp_res;
    int          mismatches;

    function automatic void emit(input kind_t k, input logic [7:0] d);
        if (step_cnt < 2)
        begin
            step_res[step_cnt].kind = k;
            step_res[step_cnt].data = d;
            step_res[step_cnt].last = 1'b0;
            step_cnt++;
        end
    endfunction

    function automatic void match_header(input logic [7:0] b);
        if (b == HEADER_TEXT[8 * (4 - hdr_matched) +: 8])
        begin
            if (hdr_matched == 3'd4)
            begin
                hdr_matched      = 3'd0;
                stage            = PH_LEN;
                frame_bytes_left = 16'd0;
                len_digit_seen   = 1'b0;
            end
            else
            begin
                hdr_matched = hdr_matched + 3'd1;
            end
        end
        else
        begin
            hdr_matched = (b == CHAR_PLUS) ? 3'd1 : 3'd0;
        end
    endfunction

    function automatic void begin_payload();
        field_left   = rem_len;
        passed_count = 10'd0;
        stage        = PH_PAYLOAD;
        if (field_left == 28'd0)
        begin
            emit(KIND_DONE, 8'h00);
            stage = PH_TAIL;
        end
    endfunction

    function automatic void end_topic();
        if (qos != 2'd0)
        begin
            field_left = 28'd2;
            stage      = PH_ID;
        end
        else
        begin
            begin_payload();
        end
    endfunction

    function automatic void consume_frame_byte(input logic [7:0] b);
        int unsigned overhead;
        frame_bytes_left = frame_bytes_left - 16'd1;
        case (stage)
            PH_FIXED:
            begin
                if (b[7:4] == 4'h3)
                begin
                    qos       = b[2:1];
                    rem_len   = 28'd0;
                    len_group = 2'd0;
                    stage     = PH_REMLEN;
                end
                else
                begin
                    stage = PH_SKIP;
                end
            end
            PH_REMLEN:
            begin
                rem_len = rem_len | (28'(b[6:0]) << (7 * len_group));
                if (b[7] && len_group < 2'd3)
                    len_group = len_group + 2'd1;
                else
                    stage = PH_TLEN_HI;
            end
            PH_TLEN_HI:
            begin
                topic_size = {b, 8'h00};
                stage      = PH_TLEN_LO;
            end
            PH_TLEN_LO:
            begin
                topic_size[7:0] = b;
                overhead        = 2 + topic_size + ((qos != 2'd0) ? 2 : 0);
                rem_len         = (rem_len > overhead) ? 28'(rem_len - overhead) : 28'd0;
                field_left      = 28'(topic_size);
                passed_count    = 10'd0;
                stage           = PH_TOPIC;
                if (field_left == 28'd0)
                    end_topic();
            end
            PH_TOPIC:
            begin
                if (passed_count < topic_max)
                begin
                    emit(KIND_TOPIC, b);
                    passed_count = passed_count + 10'd1;
                end
                field_left = field_left - 28'd1;
                if (field_left == 28'd0)
                    end_topic();
            end
            PH_ID:
            begin
                field_left = field_left - 28'd1;
                if (field_left == 28'd0)
                    begin_payload();
            end
            PH_PAYLOAD:
            begin
                if (passed_count < payload_max)
                begin
                    emit(KIND_PAYLOAD, b);
                    passed_count = passed_count + 10'd1;
                end
                field_left = field_left - 28'd1;
                if (field_left == 28'd0)
                begin
                    emit(KIND_DONE, 8'h00);
                    stage = PH_TAIL;
                end
            end
            default:
            begin
            end
        endcase
        if (frame_bytes_left == 16'd0)
        begin
            if (stage >= PH_REMLEN && stage <= PH_PAYLOAD)
                emit(KIND_DONE, 8'h00);
            else if (stage == PH_SKIP)
                emit(KIND_DROP, 8'h00);
            stage       = PH_HUNT;
            hdr_matched = 3'd0;
        end
    endfunction

    function automatic void predict_byte(input logic [7:0] b);
        int unsigned scaled;
        step_cnt = 0;
        if (stage == PH_HUNT)
        begin
            match_header(b);
        end
        else if (stage == PH_LEN)
        begin
            if (b >= CHAR_0 && b <= CHAR_9)
            begin
                scaled           = 32'(frame_bytes_left) * 10 + 32'(b - CHAR_0);
                frame_bytes_left = (scaled > 32'hFFFF) ? 16'hFFFF : 16'(scaled);
                len_digit_seen   = 1'b1;
            end
            else if (b == CHAR_COLON && len_digit_seen)
            begin
                if (frame_bytes_left == 16'd0)
                begin
                    emit(KIND_DROP, 8'h00);
                    stage       = PH_HUNT;
                    hdr_matched = 3'd0;
                end
                else if (frame_bytes_left > MAX_FRAME)
                begin
                    stage = PH_SKIP;
                end
                else
                begin
                    stage = PH_FIXED;
                end
            end
            else
            begin
                stage            = PH_HUNT;
                hdr_matched      = 3'd0;
                frame_bytes_left = 16'd0;
                match_header(b);
            end
        end
        else
        begin
            consume_frame_byte(b);
        end
        if (step_cnt > 0)
            step_res[step_cnt - 1].last = 1'b1;
        for (int i = 0; i < step_cnt; i++)
            expected_results.push_back(step_res[i]);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage            = PH_HUNT;
            hdr_matched      = 3'd0;
            frame_bytes_left = 16'd0;
            rem_len          = 28'd0;
            len_group        = 2'd0;
            qos              = 2'd0;
            topic_size       = 16'd0;
            field_left       = 28'd0;
            passed_count     = 10'd0;
            len_digit_seen   = 1'b0;
            topic_max        = TOPIC_LIMIT_RESET;
            payload_max      = PAYLOAD_LIMIT_RESET;
            mismatches       = 0;
            expected_results.delete();
            outstanding <= 0;
            errors      <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result beat: kind %0d data %02h last %0d",
                             $time, kind, data, last);
                    mismatches++;
                end
                else
                begin
                    exp_res = expected_results.pop_front();
                    if (kind !== exp_res.kind || data !== exp_res.data
                        || last !== exp_res.last)
                    begin
                        $display("%0t: mismatch: expected kind %0d data %02h last %0d, got kind %0d data %02h last %0d",
                                 $time, exp_res.kind, exp_res.data, exp_res.last,
                                 kind, data, last);
                        mismatches++;
                    end
                end
            end
            if (cfg_we)
            begin
                if (cfg_index == CFG_TOPIC_LIMIT)
                    topic_max = cfg_data;
                else
                    payload_max = cfg_data;
            end
            if (in_valid && !in_stall)
                predict_byte(rx_byte);
            outstanding <= expected_results.size();
            errors      <= mismatches;
        end
    end

endmodule

[tb/testbench.sv]
// Top of the MQTT publish extractor testbench: clock, reset, byte stimulus, limit writes,
// random output stalls, a watchdog and the verdict.
// Depends on ipd_pkg, the block ipd_mqtt_publish_extractor and ipd_publish_checker.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ipd_pkg::*;

    localparam int unsigned FRAME_MAX      = 64;
    localparam int          QUIET_LIMIT    = 2000;
    localparam int          PHASE_BYTES    = 75;
    localparam logic [71:0] SAMPLE_PUBLISH = 72'h32_07_00_01_61_12_34_FF_00;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_stall;
    logic [7:0] rx_byte   = 8'h00;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [1:0] kind;
    logic [7:0] data;
    logic       last;
    logic       cfg_we    = 1'b0;
    logic       cfg_index = CFG_TOPIC_LIMIT;
    logic [9:0] cfg_data  = 10'd0;
    logic       steady    = 1'b0;
    int         outstanding;
    int         errors;
    int         bytes_sent   = 0;
    int         quiet_cycles = 0;

    ipd_mqtt_publish_extractor #(
        .MAX_FRAME (FRAME_MAX)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .rx_byte   (rx_byte),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .kind      (kind),
        .data      (data),
        .last      (last),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    ipd_publish_checker #(
        .MAX_FRAME (FRAME_MAX)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .rx_byte     (rx_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .kind        (kind),
        .data        (data),
        .last        (last),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .outstanding (outstanding),
        .errors      (errors)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
        out_stall <= !steady && ($urandom_range(99) < 12);

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("testbench: errors");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_byte(input logic [7:0] value);
        if ($urandom_range(299) == 0)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while (outstanding != 0);
        end
        while (!steady && $urandom_range(99) < 12)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= value;
        do @(posedge clk); while (in_stall);
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    task automatic send_header(input int len, input bit zero_pad);
        send_text(zero_pad ? $sformatf("+IPD,0%0d:", len) : $sformatf("+IPD,%0d:", len));
    endtask

    task automatic send_filler(input int count);
        repeat (count) send_byte(8'($urandom_range(255)));
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_limits(input logic [9:0] topic_max, input logic [9:0] payload_max);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_TOPIC_LIMIT;
        cfg_data  <= topic_max;
        @(posedge clk);
        cfg_index <= CFG_PAYLOAD_LIMIT;
        cfg_data  <= payload_max;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_publish(input int tlen, input int plen, input int pad_to);
        logic [7:0] body [$];
        logic [7:0] fixed;
        logic [7:0] grp;
        int         rem;
        int         groups;
        int         flen;
        int         shape;
        fixed  = {4'h3, 4'($urandom_range(15))};
        shape  = (pad_to > 0) ? 0 : $urandom_range(9);
        rem    = 2 + tlen + ((fixed[2:1] != 2'd0) ? 2 : 0) + plen;
        if (shape == 8)
            rem = $urandom_range(rem - 1);
        else if (shape == 9)
            rem = $urandom_range(32'h0FFF_FFFF);
        groups = 1;
        while (groups < 4 && (rem >> (7 * groups)) != 0)
            groups++;
        if (shape == 6)
            groups = 4;
        else if (shape == 7)
            groups = $urandom_range(4, groups);
        body.push_back(fixed);
        for (int i = 0; i < groups; i++)
        begin
            grp = 8'((rem >> (7 * i)) & 127);
            if (i < groups - 1 || shape == 6)
                grp[7] = 1'b1;
            body.push_back(grp);
        end
        body.push_back(8'(tlen >> 8));
        body.push_back(8'(tlen));
        repeat (tlen) body.push_back(8'($urandom_range(255)));
        if (fixed[2:1] != 2'd0)
            repeat (2) body.push_back(8'($urandom_range(255)));
        repeat (plen) body.push_back(8'($urandom_range(255)));
        if (shape == 5)
            flen = $urandom_range(body.size(), 1);
        else if (shape == 4)
            flen = body.size() + $urandom_range(3, 1);
        else
            flen = body.size();
        if (pad_to > flen)
            flen = pad_to;
        send_header(flen, $urandom_range(4) == 0);
        for (int i = 0; i < flen; i++)
            send_byte((i < body.size()) ? body[i] : 8'($urandom_range(255)));
    endtask

    task automatic send_random_frame();
        string      alphabet;
        logic [7:0] b;
        int         pick;
        int         count;
        alphabet = "+IPD,:0123456789";
        pick     = $urandom_range(99);
        if ($urandom_range(7) == 0)
            send_byte($urandom_range(1) ? CHAR_PLUS : 8'($urandom_range(255)));
        if (pick < 70)
        begin
            send_publish(($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(10),
                         ($urandom_range(9) == 0) ? $urandom_range(80) : $urandom_range(24),
                         0);
        end
        else if (pick < 78)
        begin
            count = $urandom_range(8);
            do b = 8'($urandom_range(255)); while (b[7:4] == 4'h3);
            send_header(count + 1, $urandom_range(4) == 0);
            send_byte(b);
            send_filler(count);
        end
        else if (pick < 82)
        begin
            send_text($urandom_range(1) ? "+IPD,0:" : "+IPD,00:");
        end
        else if (pick < 90)
        begin
            send_text("+IPD,");
            count = $urandom_range(3);
            repeat (count) send_byte(CHAR_0 + 8'($urandom_range(9)));
            if (count == 0 && $urandom_range(1))
                b = CHAR_COLON;
            else if ($urandom_range(2) == 0)
                b = CHAR_PLUS;
            else
                do b = 8'($urandom_range(255));
                while ((b >= CHAR_0 && b <= CHAR_9) || b == CHAR_COLON);
            send_byte(b);
        end
        else
        begin
            repeat ($urandom_range(16, 4))
            begin
                if ($urandom_range(1))
                    send_byte(alphabet[$urandom_range(alphabet.len() - 1)]);
                else
                    send_byte(8'($urandom_range(255)));
            end
        end
    endtask

    initial
    begin
        int phase_start;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_byte(8'h00);
        send_byte(8'hFF);
        send_text("++IPD,0:");
        send_text("+IPD,9:");
        for (int i = 8; i >= 0; i--)
            send_byte(SAMPLE_PUBLISH[8 * i +: 8]);

        for (int p = 0; p < 8; p++)
        begin
            wait_idle();
            case (p)
                0: write_limits(10'd0, 10'd0);
                1: write_limits(10'd1023, 10'd1023);
                2: write_limits(10'($urandom_range(8)), 10'($urandom_range(12)));
                3: write_limits(10'($urandom_range(1023)), 10'($urandom_range(1023)));
                4: write_limits(10'd3, 10'd1023);
                5: write_limits(10'd1023, 10'd0);
                6: write_limits(10'($urandom_range(8)), 10'($urandom_range(12)));
                default: write_limits(10'd5, 10'd7);
            endcase
            steady      <= (p == 2);
            phase_start  = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES)
                send_random_frame();
            if (p == 1)
                send_publish(20, 30, FRAME_MAX);
            if (p == 5)
            begin
                send_header(FRAME_MAX + 1, 1'b0);
                send_filler(FRAME_MAX + 1);
            end
            if (p == 7)
            begin
                send_text("+IPD,65600:");
                send_filler(96);
            end
        end

        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (8) @(posedge clk);
        if (errors == 0 && outstanding == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
